FILE: rtl/tcp_passive_open_responder_unit_defines.svh
// ----------------------------------------------------------------------------
// TCP passive-open responder: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TCP_PASSIVE_OPEN_RESPONDER_UNIT_DEFINES_SVH
`define TCP_PASSIVE_OPEN_RESPONDER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// TCP passive-open responder package
// Shared types and protocol constants.
// ----------------------------------------------------------------------------
package tcpr_pkg;

    localparam logic [7:0]  FLAG_FIN    = 8'h01;
    localparam logic [7:0]  FLAG_SYN    = 8'h02;
    localparam logic [7:0]  FLAG_ACK    = 8'h10;
    localparam logic [7:0]  FLAGS_SYNACK = 8'h12;
    localparam logic [7:0]  FLAGS_FINACK = 8'h11;

    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_ACK_BIT = 4;

    localparam logic [15:0] HDR_BYTES    = 16'd20;
    localparam logic [15:0] WINDOW_VALUE = 16'hFFFF;
    localparam logic [15:0] PROTO_TCP    = 16'd6;
    localparam logic [15:0] OFFSET_WORD  = 16'h5000;

    localparam logic [31:0] LOCAL_ADDR_RESET  = 32'd0;
    localparam logic [15:0] LISTEN_PORT_RESET = 16'd80;
    localparam logic [31:0] INITIAL_SEQ_RESET = 32'd1000;

    localparam logic [1:0]  CFG_LOCAL_ADDR  = 2'd0;
    localparam logic [1:0]  CFG_LISTEN_PORT = 2'd1;
    localparam logic [1:0]  CFG_INITIAL_SEQ = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_CLOSED      = 3'b001,
        PH_SYN_RCVD    = 3'b010,
        PH_ESTABLISHED = 3'b100
    } phase_t;

    // one segment's worth of replies; a second reply is always FIN+ACK
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [31:0] seq;
        logic [31:0] ack_first;
        logic [31:0] ack_second;
        logic [7:0]  flags_first;
        logic        two;
    } job_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic        last;
    } reply_t;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [15:0] listen_port;
        logic [31:0] initial_seq;
    } cfg_t;

endpackage

FILE: rtl/tcpr_front.sv
// ----------------------------------------------------------------------------
// TCP responder front end
// Accepts segments, runs the connection record and queues reply jobs.
// ----------------------------------------------------------------------------
module tcpr_front
    import tcpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        seg_valid,
    output logic        seg_ready,
    input  logic [31:0] remote_addr,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [31:0] segment_seq,
    input  logic [7:0]  segment_flags,
    input  logic [3:0]  header_words,
    input  logic [15:0] segment_length,
    input  logic        q_ready,
    output logic        push,
    output job_t        job
);

    phase_t      phase_reg, phase_next, phase_acked;
    logic [31:0] peer_addr_reg, peer_addr_next;
    logic [15:0] peer_port_reg, peer_port_next;
    logic [15:0] own_port_reg, own_port_next;
    logic [31:0] send_seq_reg, send_seq_next;

    logic        accept;
    logic        handled;
    logic        is_syn;
    logic        is_fin;
    logic        has_data;
    logic [15:0] hdr_len;
    logic [15:0] data_len;
    logic [31:0] seq_plus_one;

    assign seg_ready = q_ready;
    assign accept    = seg_valid && seg_ready;

    always_comb
    begin
        hdr_len      = {10'd0, header_words, 2'b00};
        data_len     = segment_length - hdr_len;
        seq_plus_one = segment_seq + 32'd1;
        handled      = (segment_length >= HDR_BYTES) && (dest_port == cfg.listen_port);
        is_syn       = segment_flags[FLAG_SYN_BIT] && !segment_flags[FLAG_ACK_BIT];
        is_fin       = segment_flags[FLAG_FIN_BIT];
        phase_acked  = (segment_flags[FLAG_ACK_BIT] && phase_reg == PH_SYN_RCVD)
                     ? PH_ESTABLISHED : phase_reg;
        has_data     = (phase_acked == PH_ESTABLISHED) && (segment_length > hdr_len);

        job.addr        = peer_addr_reg;
        job.from_port   = own_port_reg;
        job.to_port     = peer_port_reg;
        job.seq         = send_seq_reg;
        job.ack_first   = seq_plus_one;
        job.ack_second  = seq_plus_one;
        job.flags_first = FLAGS_FINACK;
        job.two         = 1'b0;

        phase_next     = phase_reg;
        peer_addr_next = peer_addr_reg;
        peer_port_next = peer_port_reg;
        own_port_next  = own_port_reg;
        send_seq_next  = send_seq_reg;

        if (is_syn)
        begin
            job.addr        = remote_addr;
            job.from_port   = dest_port;
            job.to_port     = source_port;
            job.seq         = cfg.initial_seq;
            job.flags_first = FLAGS_SYNACK;
            if (accept && handled)
            begin
                phase_next     = PH_SYN_RCVD;
                peer_addr_next = remote_addr;
                peer_port_next = source_port;
                own_port_next  = dest_port;
                send_seq_next  = cfg.initial_seq + 32'd1;
            end
        end
        else
        begin
            if (has_data)
            begin
                job.ack_first   = segment_seq + {16'd0, data_len};
                job.flags_first = FLAG_ACK;
                job.two         = is_fin;
            end
            if (accept && handled)
            begin
                phase_next = is_fin ? PH_CLOSED : phase_acked;
            end
        end

        push = accept && handled && (is_syn || has_data || is_fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CLOSED;
            peer_addr_reg <= '0;
            peer_port_reg <= '0;
            own_port_reg  <= '0;
            send_seq_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            peer_addr_reg <= peer_addr_next;
            peer_port_reg <= peer_port_next;
            own_port_reg  <= own_port_next;
            send_seq_reg  <= send_seq_next;
        end
    end

endmodule

FILE: rtl/tcpr_queue.sv
// ----------------------------------------------------------------------------
// TCP responder job queue
// Two-entry FIFO between the front end and the reply builder.
// ----------------------------------------------------------------------------
`include "tcp_passive_open_responder_unit_defines.svh"

module tcpr_queue
    import tcpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic ready,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign ready      = (count_reg != 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `TCPR_ASSERT_IMPL(a_no_overflow, push, ready, "job pushed into full queue")
    `TCPR_ASSERT_IMPL(a_no_underflow, pop, head_valid, "job popped from empty queue")
    `TCPR_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue count did not rise")

endmodule

FILE: rtl/tcpr_back.sv
// ----------------------------------------------------------------------------
// TCP responder back end
// Expands queued jobs into reply headers and computes their checksums.
// ----------------------------------------------------------------------------
`include "tcp_passive_open_responder_unit_defines.svh"

module tcpr_back
    import tcpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] local_addr,
    input  logic        head_valid,
    input  job_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output reply_t      out_reply,
    output logic [15:0] out_checksum
);

    logic        part_reg, part_next;
    logic        s1_valid_reg, s1_valid_next;
    reply_t      s1_reply_reg;
    logic [19:0] s1_sum_reg;
    logic        s2_valid_reg, s2_valid_next;
    reply_t      s2_reply_reg;
    logic [15:0] s2_csum_reg;

    reply_t      cur;
    logic        s1_ready;
    logic        s2_ready;
    logic        s1_load;
    logic [19:0] cur_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb
    begin
        cur.addr      = head.addr;
        cur.from_port = head.from_port;
        cur.to_port   = head.to_port;
        cur.seq       = head.seq;
        cur.ack       = part_reg ? head.ack_second : head.ack_first;
        cur.flags     = part_reg ? FLAGS_FINACK : head.flags_first;
        cur.last      = part_reg || !head.two;

        cur_sum = 20'(local_addr[31:16]) + 20'(local_addr[15:0])
                + 20'(cur.addr[31:16])   + 20'(cur.addr[15:0])
                + 20'(PROTO_TCP)         + 20'(HDR_BYTES)
                + 20'(cur.from_port)     + 20'(cur.to_port)
                + 20'(cur.seq[31:16])    + 20'(cur.seq[15:0])
                + 20'(cur.ack[31:16])    + 20'(cur.ack[15:0])
                + 20'(OFFSET_WORD | {8'd0, cur.flags})
                + 20'(WINDOW_VALUE);

        s2_ready = !s2_valid_reg || out_ready;
        s1_ready = !s1_valid_reg || s2_ready;
        s1_load  = head_valid && s1_ready;
        pop      = s1_load && cur.last;

        part_next     = s1_load ? !cur.last : part_reg;
        s1_valid_next = s1_ready ? head_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

        fold1 = 17'(s1_sum_reg[15:0]) + 17'(s1_sum_reg[19:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            part_reg     <= part_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reply_reg <= cur;
            s1_sum_reg   <= cur_sum;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reply_reg <= s1_reply_reg;
            s2_csum_reg  <= ~fold2;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign out_reply    = s2_reply_reg;
    assign out_checksum = s2_csum_reg;

    `TCPR_ASSERT_IMPL(a_part_holds_job, part_reg, head_valid && head.two, "second reply without two-reply job")
    `TCPR_ASSERT_NEXT(a_second_follows, s1_load && !cur.last, part_reg, "second reply not selected")

endmodule

FILE: rtl/tcp_passive_open_responder_unit.sv
// ----------------------------------------------------------------------------
// TCP passive-open responder
// Keeps one connection record and answers SYN, data and FIN segments with
// checksummed 20-byte reply headers.
// ----------------------------------------------------------------------------
// The front end takes one segment per cycle while its two-entry job queue
// has room, updating the connection record in that cycle; the reply builder
// emits one reply header per cycle while the master side is ready; a segment
// with two replies (data with FIN) keeps its job at the queue head for both.
// A reply reaches the master side after its job passes the queue and the
// checksum adder and its fold, which take one pipeline stage each.
// Configuration is taken every cycle and must be written while idle.
module tcp_passive_open_responder_unit
    import tcpr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // remote_addr, source_port, dest_port, segment_seq, segment_flags,
    // header_words, segment_length, 4 zero bits
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reply_addr, reply_src_port, reply_dst_port, reply_seq, reply_ack,
    // reply_flags, reply_checksum
    output logic [151:0] m_tdata,
    output logic         m_tlast
);

    cfg_t        cfg_reg, cfg_next;
    logic        push;
    job_t        push_job;
    logic        q_ready;
    logic        pop;
    logic        head_valid;
    job_t        head;
    reply_t      reply;
    logic [15:0] checksum;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOCAL_ADDR:  cfg_next.local_addr  = cfg_data;
                CFG_LISTEN_PORT: cfg_next.listen_port = cfg_data[15:0];
                CFG_INITIAL_SEQ: cfg_next.initial_seq = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_addr  <= LOCAL_ADDR_RESET;
            cfg_reg.listen_port <= LISTEN_PORT_RESET;
            cfg_reg.initial_seq <= INITIAL_SEQ_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcpr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .seg_valid      (s_tvalid),
        .seg_ready      (s_tready),
        .remote_addr    (s_tdata[31:0]),
        .source_port    (s_tdata[47:32]),
        .dest_port      (s_tdata[63:48]),
        .segment_seq    (s_tdata[95:64]),
        .segment_flags  (s_tdata[103:96]),
        .header_words   (s_tdata[107:104]),
        .segment_length (s_tdata[123:108]),
        .q_ready        (q_ready),
        .push           (push),
        .job            (push_job)
    );

    tcpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tcpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .local_addr   (cfg_reg.local_addr),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_reply    (reply),
        .out_checksum (checksum)
    );

    assign m_tdata = {checksum, reply.flags, reply.ack, reply.seq,
                      reply.to_port, reply.from_port, reply.addr};
    assign m_tlast = reply.last;

endmodule

FILE: bench/tcp_passive_open_responder_unit_tb.sv
// ----------------------------------------------------------------------------
// TCP passive-open responder testbench
// Drives parsed segments on the slave stream and configuration writes while
// idle. A local model of the connection record predicts every reply header
// and its checksum, and each reply on the master stream is checked field by
// field. Directed segments cover drops, handshake, data, FIN and flag
// combinations. Random connections and noise run under several idle/stall
// mixes.
// ----------------------------------------------------------------------------
module tcp_passive_open_responder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpr_pkg::*;

    localparam logic [1:0] CFG_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] remote_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq;
        logic [7:0]  flags;
        logic [3:0]  words;
        logic [15:0] length;
    } segment_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] checksum;
        logic        last;
    } hdr_reply_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tlast;

    // connection record and registers as predicted
    logic [31:0] local_addr = LOCAL_ADDR_RESET;
    logic [15:0] listen_port = LISTEN_PORT_RESET;
    logic [31:0] initial_seq = INITIAL_SEQ_RESET;
    phase_t      conn_phase = PH_CLOSED;
    logic [31:0] peer_addr = '0;
    logic [15:0] peer_port = '0;
    logic [15:0] own_port = '0;
    logic [31:0] send_seq = '0;
    logic [31:0] ack_value = '0;

    hdr_reply_t pending_replies[$];
    int         served_segments = 0;
    int         error_count = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         quiet_cycles = 0;

    tcp_passive_open_responder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] header_checksum(logic [31:0] dst, logic [15:0] sport,
                                                    logic [15:0] dport, logic [31:0] seq,
                                                    logic [31:0] ack, logic [7:0] flags);
        logic [31:0] sum;
        sum = 32'(local_addr[31:16]) + 32'(local_addr[15:0]) + 32'(dst[31:16])
            + 32'(dst[15:0]) + 32'(PROTO_TCP) + 32'(HDR_BYTES) + 32'(sport) + 32'(dport)
            + 32'(seq[31:16]) + 32'(seq[15:0]) + 32'(ack[31:16]) + 32'(ack[15:0])
            + 32'(OFFSET_WORD | {8'h00, flags}) + 32'(WINDOW_VALUE);
        while (sum[31:16] != 16'h0000)
            sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        return ~sum[15:0];
    endfunction

    function automatic void queue_reply(logic [7:0] flags, logic last);
        hdr_reply_t r;
        r.addr      = peer_addr;
        r.from_port = own_port;
        r.to_port   = peer_port;
        r.seq       = send_seq;
        r.ack       = ack_value;
        r.flags     = flags;
        r.checksum  = header_checksum(peer_addr, own_port, peer_port, send_seq, ack_value,
                                      flags);
        r.last      = last;
        pending_replies.push_back(r);
    endfunction

    function automatic void respond_to_segment(segment_t seg);
        logic [31:0] hdr_len;
        logic [31:0] seg_len;
        hdr_len = 32'(seg.words) * 4;
        seg_len = 32'(seg.length);
        if (seg_len < 32'(HDR_BYTES) || seg.dest_port != listen_port)
            return;
        served_segments++;
        if (seg.flags[FLAG_SYN_BIT] && !seg.flags[FLAG_ACK_BIT])
        begin
            peer_addr  = seg.remote_addr;
            peer_port  = seg.source_port;
            own_port   = seg.dest_port;
            send_seq   = initial_seq;
            ack_value  = seg.seq + 32'd1;
            conn_phase = PH_SYN_RCVD;
            queue_reply(FLAGS_SYNACK, 1'b1);
            send_seq   = send_seq + 32'd1;
            return;
        end
        if (seg.flags[FLAG_ACK_BIT] && conn_phase == PH_SYN_RCVD)
            conn_phase = PH_ESTABLISHED;
        if (conn_phase == PH_ESTABLISHED && seg_len > hdr_len)
        begin
            ack_value = seg.seq + (seg_len - hdr_len);
            queue_reply(FLAG_ACK, !seg.flags[FLAG_FIN_BIT]);
        end
        if (seg.flags[FLAG_FIN_BIT])
        begin
            ack_value  = seg.seq + 32'd1;
            queue_reply(FLAGS_FINACK, 1'b1);
            conn_phase = PH_CLOSED;
        end
    endfunction

    function automatic segment_t seg_of(logic [31:0] addr, logic [15:0] sport,
                                        logic [15:0] dport, logic [31:0] seq,
                                        logic [7:0] flags, logic [3:0] words,
                                        logic [15:0] length);
        segment_t seg;
        seg.remote_addr = addr;
        seg.source_port = sport;
        seg.dest_port   = dport;
        seg.seq         = seq;
        seg.flags       = flags;
        seg.words       = words;
        seg.length      = length;
        return seg;
    endfunction

    task automatic send_segment(segment_t seg);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, seg.length, seg.words, seg.flags, seg.seq, seg.dest_port,
                     seg.source_port, seg.remote_addr};
        do
            @(posedge clk);
        while (!s_tready);
        respond_to_segment(seg);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_LOCAL_ADDR:  local_addr  = value;
            CFG_LISTEN_PORT: listen_port = value[15:0];
            CFG_INITIAL_SEQ: initial_seq = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (expected !== actual)
        begin
            $error("%s expected %h got %h", name, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        hdr_reply_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                check_field("reply_addr", exp_r.addr, m_tdata[31:0]);
                check_field("reply_src_port", 32'(exp_r.from_port), 32'(m_tdata[47:32]));
                check_field("reply_dst_port", 32'(exp_r.to_port), 32'(m_tdata[63:48]));
                check_field("reply_seq", exp_r.seq, m_tdata[95:64]);
                check_field("reply_ack", exp_r.ack, m_tdata[127:96]);
                check_field("reply_flags", 32'(exp_r.flags), 32'(m_tdata[135:128]));
                check_field("reply_checksum", 32'(exp_r.checksum), 32'(m_tdata[151:136]));
                check_field("last_reply", 32'(exp_r.last), 32'(m_tlast));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tcp_passive_open_responder_unit: mismatch");
            $finish;
        end
    end

    // register values after reset
    task automatic test_reset_defaults();
        send_segment(seg_of(32'hC0A8_0001, 16'd1234, 16'd80, 32'h10, FLAG_FIN, 4'd5, 16'd20));
        send_segment(seg_of(32'hC0A8_0002, 16'd1, 16'd80, 32'h0, FLAG_SYN, 4'd5, 16'd19));
        send_segment(seg_of(32'hC0A8_0002, 16'd1, 16'd80, 32'h0, FLAG_SYN, 4'd0, 16'd0));
        send_segment(seg_of(32'hC0A8_0002, 16'd1, 16'd81, 32'h0, FLAG_SYN, 4'd5, 16'd40));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'hFFFF_FFFF, FLAG_SYN, 4'd5,
                            16'd20));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'h0, 8'h00, 4'd5, 16'd100));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'h0, FLAG_ACK, 4'd5, 16'd120));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'd100, FLAG_ACK, 4'd15,
                            16'd60));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'd100, FLAG_ACK, 4'd15,
                            16'd40));
        send_segment(seg_of(32'hFFFF_FFFF, 16'hFFFF, 16'd80, 32'hFFFF_FF00,
                            FLAG_ACK | FLAG_FIN, 4'd8, 16'd532));
        send_segment(seg_of(32'h0, 16'h0, 16'd80, 32'h0, FLAG_SYN | FLAG_FIN, 4'd5, 16'd20));
        send_segment(seg_of(32'h0, 16'h0, 16'd80, 32'h5, 8'hFF, 4'd5, 16'd20));
        send_segment(seg_of(32'h0A0B_0C0D, 16'd5, 16'd80, 32'h7, FLAGS_SYNACK, 4'd5, 16'd20));
        send_segment(seg_of(32'h0A0B_0C0D, 16'd5, 16'd80, 32'h7, FLAG_ACK, 4'd0, 16'hFFFF));
        send_segment(seg_of(32'h0A0B_0C0D, 16'd5, 16'd80, 32'h8000_0000, FLAG_SYN, 4'd5,
                            16'd20));
        send_segment(seg_of(32'h0A0B_0C0D, 16'd5, 16'd80, 32'h8000_0001, FLAG_ACK, 4'd0,
                            16'hFFFF));
        settle();
    endtask

    // all-ones and all-zero register settings
    task automatic test_config_extremes();
        write_reg(CFG_LOCAL_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_LISTEN_PORT, 32'hFFFF_FFFF);
        write_reg(CFG_INITIAL_SEQ, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        send_segment(seg_of(32'h0102_0304, 16'd4000, 16'hFFFF, 32'h1, FLAG_SYN, 4'd5, 16'd20));
        send_segment(seg_of(32'h0102_0304, 16'd4000, 16'd80, 32'h2, FLAG_ACK, 4'd5, 16'd200));
        send_segment(seg_of(32'h0102_0304, 16'd4000, 16'hFFFF, 32'h2, 8'h18, 4'd5, 16'd1500));
        send_segment(seg_of(32'h0102_0304, 16'd4000, 16'hFFFF, 32'h5D2, FLAG_ACK | FLAG_FIN,
                            4'd5, 16'd20));
        settle();
        write_reg(CFG_LOCAL_ADDR, 32'h0);
        write_reg(CFG_LISTEN_PORT, 32'h0);
        write_reg(CFG_INITIAL_SEQ, 32'h0);
        send_segment(seg_of(32'h0A00_0001, 16'd8080, 16'd0, 32'h100, FLAG_SYN, 4'd5, 16'd20));
        send_segment(seg_of(32'h0A00_0001, 16'd8080, 16'd0, 32'h101, FLAG_ACK | FLAG_FIN,
                            4'd6, 16'd64));
        send_segment(seg_of(32'h0A00_0001, 16'd8080, 16'd0, 32'h200, FLAG_FIN, 4'd5, 16'd20));
        settle();
    endtask

    task automatic random_connection();
        logic [31:0] addr;
        logic [15:0] sport;
        logic [31:0] seq;
        logic [3:0]  words;
        logic [15:0] len;
        int          data_count;
        addr  = $urandom;
        sport = 16'($urandom);
        seq   = $urandom;
        send_segment(seg_of(addr, sport, listen_port, seq,
                            (8'($urandom) & 8'hED) | FLAG_SYN, 4'($urandom_range(5, 15)),
                            16'($urandom_range(20, 200))));
        seq = seq + 32'd1;
        if ($urandom_range(0, 9) != 0)
            send_segment(seg_of(addr, sport, listen_port, seq,
                                (8'($urandom) & 8'hEC) | FLAG_ACK, 4'd5, 16'd20));
        data_count = $urandom_range(0, 4);
        repeat (data_count)
        begin
            words = 4'($urandom_range(5, 15));
            if ($urandom_range(0, 9) == 0)
                len = 16'($urandom);
            else
                len = 16'(32'(words) * 4 + $urandom_range(0, 1460));
            send_segment(seg_of(addr, sport, listen_port, seq,
                                (8'($urandom) & 8'hEC) | FLAG_ACK, words, len));
            if (32'(len) > 32'(words) * 4)
                seq = seq + 32'(len) - 32'(words) * 4;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            words = 4'($urandom_range(5, 15));
            len = 16'(32'(words) * 4 + ($urandom_range(0, 1) ? $urandom_range(1, 500) : 0));
            send_segment(seg_of(addr, sport, listen_port, seq,
                                (8'($urandom) & 8'hEC) | FLAG_ACK | FLAG_FIN, words, len));
        end
    endtask

    task automatic random_noise();
        logic [15:0] dport;
        logic [15:0] len;
        dport = $urandom_range(0, 1) ? listen_port : 16'($urandom);
        len   = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 40)) : 16'($urandom);
        send_segment(seg_of($urandom, 16'($urandom), dport, $urandom, 8'($urandom),
                            4'($urandom), len));
    endtask

    task automatic run_random(int target);
        int start;
        start = served_segments;
        while (served_segments - start < target)
        begin
            if ($urandom_range(0, 99) < 75)
                random_connection();
            else
                random_noise();
        end
    endtask

    // random traffic under each idle/stall mix, new registers per phase
    task automatic test_random_traffic();
        int sender_mix[4] = '{0, 73, 0, 11};
        int receiver_mix[4] = '{0, 0, 73, 11};
        for (int p = 0; p < 4; p++)
        begin
            settle();
            write_reg(CFG_LOCAL_ADDR, $urandom);
            write_reg(CFG_LISTEN_PORT, $urandom_range(0, 1) ? 32'd80 : $urandom);
            write_reg(CFG_INITIAL_SEQ, $urandom);
            idle_pct  = sender_mix[p];
            stall_pct = receiver_mix[p];
            run_random(100);
            wait_for_replies();
            run_random(100);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();
        wait_for_replies();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (error_count == 0)
            $display("tcp_passive_open_responder_unit: match");
        else
            $display("tcp_passive_open_responder_unit: mismatch");
        $finish;
    end

endmodule
